// File: rtl/mapped_image_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mapped image sampler unit
// Each macro expands to a concurrent assertion on i_clk with i_rst_n as the
// disable condition, or to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MAPPED_IMAGE_SAMPLER_UNIT_MACROS_SVH
`define MAPPED_IMAGE_SAMPLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must never hold at a clock edge.
`define MSU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
// Precondition implies postcondition in the same cycle.
`define MSU_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define MSU_ASSERT_NEVER(lbl, cond, msg)
`define MSU_ASSERT_IMPLY(lbl, pre, post, msg)
`endif
`endif

// File: rtl/msu_pkg.sv
// ----------------------------------------------------------------------------
// msu_pkg
// Shared types, codes and constants of the mapped image sampler unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msu_pkg;

    // Default image store geometry
    localparam int DEF_WIDTH  = 256;
    localparam int DEF_HEIGHT = 256;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Input command codes
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    // Sampling method codes
    typedef enum logic {
        METHOD_NEAREST  = 1'b0,
        METHOD_BILINEAR = 1'b1
    } t_method;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_SCALE        = 3'd2,
        CFG_METHOD       = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    // Classified work item kinds carried through the queue
    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_OUTSIDE = 2'd2
    } t_kind;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Configuration reset values
    localparam logic [31:0] RST_ORIGIN   = 32'd0;
    localparam logic [31:0] RST_SCALE    = 32'd65536;
    localparam t_method     RST_METHOD   = METHOD_BILINEAR;
    localparam logic [8:0]  RST_EXTENT   = 9'd256;

    // Queue entry: kind, c0, c1, r0, r1, fx, fy, pixel (lowest bits first)
    function automatic int entry_w(input int cw, input int rw);
        return $bits(t_kind) + 2 * cw + 2 * rw + 16 + 16 + 8;
    endfunction

endpackage

// File: rtl/msu_front.sv
// ----------------------------------------------------------------------------
// msu_front
// Holds the configuration, accepts items, maps sample points to image
// coordinates and classifies each item into a queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msu_front
    import msu_pkg::*;
#(
    parameter int WIDTH   = DEF_WIDTH,
    parameter int HEIGHT  = DEF_HEIGHT,
    parameter int ENTRY_W = entry_w($clog2(DEF_WIDTH), $clog2(DEF_HEIGHT))
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [7:0]            i_col,
    input  logic [7:0]            i_row,
    input  logic [7:0]            i_pix,
    input  logic [31:0]           i_qx,
    input  logic [31:0]           i_qy,
    // queue write side
    output logic                  o_push,
    output logic [ENTRY_W-1:0]    o_entry,
    input  t_q_stat               i_qstat
);

    localparam int CW  = $clog2(WIDTH);
    localparam int RW  = $clog2(HEIGHT);
    localparam int XW  = $clog2(WIDTH + 1);
    localparam int YW  = $clog2(HEIGHT + 1);
    localparam int EXW = (XW > 9) ? XW : 9;
    localparam int EYW = (YW > 9) ? YW : 9;

    // configuration registers
    logic [31:0] r_origin_x;
    logic [31:0] r_origin_y;
    logic [31:0] r_scale;
    t_method     r_method;
    logic [8:0]  r_img_w;
    logic [8:0]  r_img_h;

    // stage 1: captured item and offsets from the origin
    logic        r1_valid;
    t_cmd        r1_cmd;
    logic [7:0]  r1_col;
    logic [7:0]  r1_row;
    logic [7:0]  r1_pix;
    logic [32:0] r1_dx;
    logic [32:0] r1_dy;

    // stage 2: scaled coordinates
    logic        r2_valid;
    t_cmd        r2_cmd;
    logic [7:0]  r2_col;
    logic [7:0]  r2_row;
    logic [7:0]  r2_pix;
    logic [63:0] r2_prod_x;
    logic [63:0] r2_prod_y;
    logic        r2_neg_x;
    logic        r2_neg_y;

    logic          w_advance;
    logic [XW-1:0] w_ext_w;
    logic [YW-1:0] w_ext_h;
    logic [63:0]   w_prod_x;
    logic [63:0]   w_prod_y;
    logic          w_out_x;
    logic          w_out_y;
    logic [XW-1:0] w_ix;
    logic [YW-1:0] w_iy;
    logic          w_drop;
    t_kind         w_kind;
    logic [CW-1:0] w_c0;
    logic [CW-1:0] w_c1;
    logic [RW-1:0] w_r0;
    logic [RW-1:0] w_r1;
    logic [15:0]   w_fx;
    logic [15:0]   w_fy;
    logic [7:0]    w_epix;

    // Clamp a column index to the last column in use
    function automatic logic [CW-1:0] clamp_c(input logic [XW:0] v, input logic [XW-1:0] n);
        return (v >= {1'b0, n}) ? CW'(n - 1'b1) : CW'(v);
    endfunction

    // Clamp a row index to the last row in use
    function automatic logic [RW-1:0] clamp_r(input logic [YW:0] v, input logic [YW-1:0] n);
        return (v >= {1'b0, n}) ? RW'(n - 1'b1) : RW'(v);
    endfunction

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= RST_ORIGIN;
            r_origin_y <= RST_ORIGIN;
            r_scale    <= RST_SCALE;
            r_method   <= RST_METHOD;
            r_img_w    <= RST_EXTENT;
            r_img_h    <= RST_EXTENT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:     r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y:     r_origin_y <= i_cfg_data;
                CFG_SCALE:        r_scale    <= i_cfg_data;
                CFG_METHOD:       r_method   <= t_method'(i_cfg_data[0]);
                CFG_IMAGE_WIDTH:  r_img_w    <= i_cfg_data[8:0];
                CFG_IMAGE_HEIGHT: r_img_h    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Effective extents: zero counts as one, large values saturate at the store
    always_comb begin
        if (r_img_w == '0) begin
            w_ext_w = XW'(1);
        end else if (EXW'(r_img_w) > EXW'(WIDTH)) begin
            w_ext_w = XW'(WIDTH);
        end else begin
            w_ext_w = XW'(r_img_w);
        end
        if (r_img_h == '0) begin
            w_ext_h = YW'(1);
        end else if (EYW'(r_img_h) > EYW'(HEIGHT)) begin
            w_ext_h = YW'(HEIGHT);
        end else begin
            w_ext_h = YW'(r_img_h);
        end
    end

    // Advance the front pipeline whenever its last stage can drain
    assign w_advance = !r2_valid || !i_qstat.full;
    assign o_ready   = w_advance;

    // Stage 1: capture the transfer and subtract the origin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_advance) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r1_cmd <= t_cmd'(i_cmd);
            r1_col <= i_col;
            r1_row <= i_row;
            r1_pix <= i_pix;
            r1_dx  <= {i_qx[31], i_qx} - {r_origin_x[31], r_origin_x};
            r1_dy  <= {i_qy[31], i_qy} - {r_origin_y[31], r_origin_y};
        end
    end

    // Stage 2: scale the offsets, one 32 by 32 product per axis
    assign w_prod_x = {32'b0, r1_dx[31:0]} * {32'b0, r_scale};
    assign w_prod_y = {32'b0, r1_dy[31:0]} * {32'b0, r_scale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_advance) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r2_cmd    <= r1_cmd;
            r2_col    <= r1_col;
            r2_row    <= r1_row;
            r2_pix    <= r1_pix;
            r2_prod_x <= w_prod_x;
            r2_prod_y <= w_prod_y;
            r2_neg_x  <= r1_dx[32] && (r_scale != '0);
            r2_neg_y  <= r1_dy[32] && (r_scale != '0);
        end
    end

    // Bounds test: a point exactly on the far edge is still inside
    assign w_out_x = r2_neg_x || (r2_prod_x[63:32] > 32'(w_ext_w)) ||
                     ((r2_prod_x[63:32] == 32'(w_ext_w)) && (r2_prod_x[31:0] != '0));
    assign w_out_y = r2_neg_y || (r2_prod_y[63:32] > 32'(w_ext_h)) ||
                     ((r2_prod_y[63:32] == 32'(w_ext_h)) && (r2_prod_y[31:0] != '0));
    assign w_ix    = r2_prod_x[XW+31:32];
    assign w_iy    = r2_prod_y[YW+31:32];

    // Classify the item and build its queue entry
    always_comb begin
        w_drop = 1'b0;
        w_kind = KIND_SAMPLE;
        w_c0   = '0;
        w_c1   = '0;
        w_r0   = '0;
        w_r1   = '0;
        w_fx   = '0;
        w_fy   = '0;
        w_epix = '0;
        if (r2_cmd == CMD_LOAD) begin
            // loads beyond the store are dropped
            w_drop = ({24'b0, r2_col} >= 32'(WIDTH)) || ({24'b0, r2_row} >= 32'(HEIGHT));
            w_kind = KIND_LOAD;
            w_c0   = CW'(r2_col);
            w_c1   = CW'(r2_col);
            w_r0   = RW'(r2_row);
            w_r1   = RW'(r2_row);
            w_epix = r2_pix;
        end else if (w_out_x || w_out_y) begin
            w_kind = KIND_OUTSIDE;
        end else if (r_method == METHOD_NEAREST) begin
            // round half up, then a single pixel with zero weights
            w_c0 = clamp_c({1'b0, w_ix} + (XW + 1)'(r2_prod_x[31]), w_ext_w);
            w_c1 = w_c0;
            w_r0 = clamp_r({1'b0, w_iy} + (YW + 1)'(r2_prod_y[31]), w_ext_h);
            w_r1 = w_r0;
        end else begin
            w_c0 = clamp_c({1'b0, w_ix}, w_ext_w);
            w_c1 = clamp_c({1'b0, w_ix} + 1'b1, w_ext_w);
            w_r0 = clamp_r({1'b0, w_iy}, w_ext_h);
            w_r1 = clamp_r({1'b0, w_iy} + 1'b1, w_ext_h);
            w_fx = r2_prod_x[31:16];
            w_fy = r2_prod_y[31:16];
        end
    end

    assign o_push  = r2_valid && !w_drop && !i_qstat.full;
    assign o_entry = {w_epix, w_fy, w_fx, w_r1, w_r0, w_c1, w_c0, w_kind};

endmodule

// File: rtl/msu_queue.sv
// ----------------------------------------------------------------------------
// msu_queue
// Short first-in first-out queue of classified entries between the front
// and the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msu_queue
    import msu_pkg::*;
#(
    parameter int ENTRY_W = entry_w($clog2(DEF_WIDTH), $clog2(DEF_HEIGHT))
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [ENTRY_W-1:0] i_entry,
    input  logic               i_pop,
    output logic [ENTRY_W-1:0] o_entry,
    output t_q_stat            o_stat
);

    localparam int PW   = $clog2(Q_DEPTH);
    localparam int CNTW = $clog2(Q_DEPTH + 1);

    logic [ENTRY_W-1:0] r_slot [Q_DEPTH];
    logic [PW-1:0]      r_wp;
    logic [PW-1:0]      r_rp;
    logic [CNTW-1:0]    r_cnt;
    logic [PW-1:0]      n_wp;
    logic [PW-1:0]      n_rp;

    // Wrap pointers at the queue depth
    assign n_wp = (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_entry;
        end
    end

    assign o_entry      = r_slot[r_rp];
    assign o_stat.full  = (r_cnt == CNTW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// File: rtl/msu_back.sv
// ----------------------------------------------------------------------------
// msu_back
// Carries out queue entries: writes loads into four parity banks of the
// image store, reads the four neighbours of a sample and interpolates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msu_back
    import msu_pkg::*;
#(
    parameter int WIDTH   = DEF_WIDTH,
    parameter int HEIGHT  = DEF_HEIGHT,
    parameter int ENTRY_W = entry_w($clog2(DEF_WIDTH), $clog2(DEF_HEIGHT))
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // queue read side
    input  logic [ENTRY_W-1:0] i_entry,
    input  t_q_stat            i_qstat,
    output logic               o_pop,
    // result items
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_value,
    output logic               o_outside
);

    localparam int CW         = $clog2(WIDTH);
    localparam int RW         = $clog2(HEIGHT);
    localparam int BCW        = (CW > 1) ? CW - 1 : 1;
    localparam int BRW        = (RW > 1) ? RW - 1 : 1;
    localparam int BANK_DEPTH = 1 << (BCW + BRW);

    // unpacked queue entry
    t_kind         w_kind;
    logic [1:0]    w_kind_bits;
    logic [CW-1:0] w_c0;
    logic [CW-1:0] w_c1;
    logic [RW-1:0] w_r0;
    logic [RW-1:0] w_r1;
    logic [15:0]   w_fx;
    logic [15:0]   w_fy;
    logic [7:0]    w_epix;

    logic w_adv;

    // stage 1: bank read data and entry attributes
    logic [7:0]  r_rd [4];
    logic        r_b1_valid;
    logic        r_b1_out;
    logic [15:0] r_b1_fx;
    logic [15:0] r_b1_fy;
    logic [3:0]  r_b1_par;

    // stage 2: row mixes
    logic        r_b2_valid;
    logic        r_b2_out;
    logic [15:0] r_b2_fy;
    logic [23:0] r_b2_top;
    logic [23:0] r_b2_bot;

    // stage 3: column mix
    logic        r_b3_valid;
    logic        r_b3_out;
    logic [39:0] r_b3_acc;

    // output register
    logic        r_ov;
    logic [15:0] r_oval;
    logic        r_oout;

    logic [7:0]  w_p00;
    logic [7:0]  w_p10;
    logic [7:0]  w_p01;
    logic [7:0]  w_p11;
    logic [16:0] w_wx0;
    logic [16:0] w_wy0;
    logic [24:0] w_top;
    logic [24:0] w_bot;
    logic [40:0] w_acc;
    logic [39:0] w_round;

    // Pick one bank's read data by row and column parity
    function automatic logic [7:0] pick(input logic [7:0] d0, input logic [7:0] d1,
                                        input logic [7:0] d2, input logic [7:0] d3,
                                        input logic rp, input logic cp);
        logic [7:0] v;
        case ({rp, cp})
            2'b00:   v = d0;
            2'b01:   v = d1;
            2'b10:   v = d2;
            default: v = d3;
        endcase
        return v;
    endfunction

    assign {w_epix, w_fy, w_fx, w_r1, w_r0, w_c1, w_c0, w_kind_bits} = i_entry;
    assign w_kind = t_kind'(w_kind_bits);

    // Advance the back pipeline when the output register is free or taken
    assign w_adv = !r_ov || i_ready;
    assign o_pop = w_adv && !i_qstat.empty;

    // Image store banks: bank index is row parity then column parity
    for (genvar b = 0; b < 4; b++) begin : gen_bank
        localparam bit CP = (b % 2) == 1;
        localparam bit RP = (b / 2) == 1;

        logic [7:0]           r_mem [BANK_DEPTH];
        logic [CW-1:0]        w_col_sel;
        logic [RW-1:0]        w_row_sel;
        logic [BCW+BRW-1:0]   w_addr;
        logic                 w_we;

        // pick the neighbour of this bank's parity on each axis
        assign w_col_sel = (w_c0[0] == CP) ? w_c0 : w_c1;
        assign w_row_sel = (w_r0[0] == RP) ? w_r0 : w_r1;
        assign w_addr    = {BRW'(w_row_sel >> 1), BCW'(w_col_sel >> 1)};
        assign w_we      = o_pop && (w_kind == KIND_LOAD) && (w_c0[0] == CP) &&
                           (w_r0[0] == RP);

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_addr] <= w_epix;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rd[b] <= r_mem[w_addr];
            end
        end
    end

    // Stage 1: entry attributes beside the bank reads; loads end here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (w_adv) begin
            r_b1_valid <= o_pop && (w_kind != KIND_LOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b1_out <= (w_kind == KIND_OUTSIDE);
            r_b1_fx  <= w_fx;
            r_b1_fy  <= w_fy;
            r_b1_par <= {w_r1[0], w_r0[0], w_c1[0], w_c0[0]};
        end
    end

    // Stage 2: mix along columns for the upper and lower rows
    assign w_p00 = pick(r_rd[0], r_rd[1], r_rd[2], r_rd[3], r_b1_par[2], r_b1_par[0]);
    assign w_p10 = pick(r_rd[0], r_rd[1], r_rd[2], r_rd[3], r_b1_par[2], r_b1_par[1]);
    assign w_p01 = pick(r_rd[0], r_rd[1], r_rd[2], r_rd[3], r_b1_par[3], r_b1_par[0]);
    assign w_p11 = pick(r_rd[0], r_rd[1], r_rd[2], r_rd[3], r_b1_par[3], r_b1_par[1]);
    assign w_wx0 = 17'h10000 - {1'b0, r_b1_fx};
    assign w_top = 25'(w_p00) * 25'(w_wx0) + 25'(w_p10) * 25'(r_b1_fx);
    assign w_bot = 25'(w_p01) * 25'(w_wx0) + 25'(w_p11) * 25'(r_b1_fx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
        end else if (w_adv) begin
            r_b2_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b2_out <= r_b1_out;
            r_b2_fy  <= r_b1_fy;
            r_b2_top <= w_top[23:0];
            r_b2_bot <= w_bot[23:0];
        end
    end

    // Stage 3: mix the two rows
    assign w_wy0 = 17'h10000 - {1'b0, r_b2_fy};
    assign w_acc = 41'(r_b2_top) * 41'(w_wy0) + 41'(r_b2_bot) * 41'(r_b2_fy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b3_valid <= 1'b0;
        end else if (w_adv) begin
            r_b3_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b3_out <= r_b2_out;
            r_b3_acc <= w_acc[39:0];
        end
    end

    // Output: round half up to Q8.8, force zero for points outside
    assign w_round = r_b3_acc + 40'h0000800000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_b3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_oval <= r_b3_out ? 16'd0 : w_round[39:24];
            r_oout <= r_b3_out;
        end
    end

    assign o_valid   = r_ov;
    assign o_value   = r_oval;
    assign o_outside = r_oout;

endmodule

// File: rtl/mapped_image_sampler_unit.sv
// Loads give no result; a sample passes front, queue, back stages and the output register.
// Throughput: one item per cycle, loads and samples mixed, when the output is not stalled.
// The rate is set by four image banks split by row and column parity, one read each per cycle.
// Reset (synchronous, active low) clears pipeline and queue and resets the configuration.
// The image store is not cleared; every pixel a sample reads must be loaded after reset.
// ----------------------------------------------------------------------------
// mapped_image_sampler_unit
// Grayscale image store sampled at world coordinates by nearest neighbour or
// bilinear interpolation, with a front that maps points and a back that
// reads the store and interpolates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "mapped_image_sampler_unit_macros.svh"

module mapped_image_sampler_unit
    import msu_pkg::*;
#(
    parameter int WIDTH  = DEF_WIDTH,
    parameter int HEIGHT = DEF_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: pixel_col[7:0], pixel_row[15:8], pixel_value[23:16],
    //        query_x[55:24], query_y[87:56]
    input  logic [87:0]           s_axis_tdata,
    // tuser: command[0]
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: sample_value[15:0]
    output logic [15:0]           m_axis_tdata,
    // tuser: outside[0]
    output logic                  m_axis_tuser
);

    localparam int CW      = $clog2(WIDTH);
    localparam int RW      = $clog2(HEIGHT);
    localparam int ENTRY_W = entry_w(CW, RW);

    logic               w_push;
    logic               w_pop;
    logic [ENTRY_W-1:0] w_entry_in;
    logic [ENTRY_W-1:0] w_entry_out;
    t_q_stat            w_qstat;

    // Map and classify items
    msu_front #(
        .WIDTH   (WIDTH),
        .HEIGHT  (HEIGHT),
        .ENTRY_W (ENTRY_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_col      (s_axis_tdata[7:0]),
        .i_row      (s_axis_tdata[15:8]),
        .i_pix      (s_axis_tdata[23:16]),
        .i_qx       (s_axis_tdata[55:24]),
        .i_qy       (s_axis_tdata[87:56]),
        .o_push     (w_push),
        .o_entry    (w_entry_in),
        .i_qstat    (w_qstat)
    );

    // Decouple front and back
    msu_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry_in),
        .i_pop   (w_pop),
        .o_entry (w_entry_out),
        .o_stat  (w_qstat)
    );

    // Store access and interpolation
    msu_back #(
        .WIDTH   (WIDTH),
        .HEIGHT  (HEIGHT),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (w_entry_out),
        .i_qstat   (w_qstat),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (m_axis_tdata),
        .o_outside (m_axis_tuser)
    );

    // Queue never overflows or underflows
    `MSU_ASSERT_NEVER(a_push_when_full, w_push && w_qstat.full, "queue push while full")
    `MSU_ASSERT_NEVER(a_pop_when_empty, w_pop && w_qstat.empty, "queue pop while empty")
    // Outside results carry a zero value
    `MSU_ASSERT_IMPLY(a_outside_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0, "outside result not zero")
    // Interpolated values stay within the gray range
    `MSU_ASSERT_IMPLY(a_value_range, m_axis_tvalid, m_axis_tdata <= 16'hFF00, "sample value above range")

endmodule

// File: test/mapped_image_sampler_unit_test.sv
// ----------------------------------------------------------------------------
// mapped_image_sampler_unit_test
// Self-checking bench for the mapped image sampler. A queue of pixel loads and
// world-point samples feeds a stream driver; a model of the image store
// and the coordinate mapping predicts each sample, and a monitor compares the
// returned value and outside flag field by field. Phases change origin,
// scale, method and image extent, including zero scale, maximum scale, zero
// and oversized extents, and apply idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mapped_image_sampler_unit_test;
    import msu_pkg::*;

    localparam int unsigned WIDTH_PX   = DEF_WIDTH;
    localparam int unsigned HEIGHT_PX  = DEF_HEIGHT;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 3000;

    // One input item: load or sample
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  val;
        logic [31:0] qx;
        logic [31:0] qy;
    } t_pixel_op;

    // One returned sample
    typedef struct packed {
        logic        outside;
        logic [15:0] value;
    } t_sample;

    // Neighbour taps and weights of one sample point
    typedef struct packed {
        logic        outside;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  r0;
        logic [7:0]  r1;
        logic [15:0] fx;
        logic [15:0] fy;
    } t_taps;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [87:0]           s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;
    logic                  m_axis_tuser;

    // Configuration copy used for prediction and stimulus
    logic [31:0] cfg_origin_x;
    logic [31:0] cfg_origin_y;
    logic [31:0] cfg_scale;
    t_method     cfg_method;
    logic [8:0]  cfg_width;
    logic [8:0]  cfg_height;

    // Image model, and the set of pixels the stimulus has already loaded
    logic [7:0]  img_model [0:65535];
    bit          gen_loaded [0:65535];

    t_pixel_op   pending_ops[$];
    t_sample     expected_samples[$];

    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_cnt = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    t_pixel_op   sent_op;
    t_sample     want;

    mapped_image_sampler_unit #(
        .WIDTH (DEF_WIDTH),
        .HEIGHT(DEF_HEIGHT)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Effective extent of the image in use
    function automatic int unsigned axis_extent(input logic [8:0] r, input int unsigned lim);
        if (r == 0) return 1;
        if (r > lim) return lim;
        return r;
    endfunction

    // Map one axis to Q.16 pixel units; return 1 when the point is off the image
    function automatic logic map_axis(input logic [31:0] q, input logic [31:0] org,
                                      input logic [31:0] sc, input int unsigned n,
                                      output logic [47:0] p);
        longint     d;
        logic [63:0] prod;
        d = longint'($signed(q)) - longint'($signed(org));
        p = '0;
        if (sc == 0) begin
            prod = '0;
        end else if (d < 0) begin
            return 1'b1;
        end else begin
            prod = 64'(d) * {32'd0, sc};
        end
        if (prod > (64'(n) << 32)) return 1'b1;
        p = prod[63:16];
        return 1'b0;
    endfunction

    function automatic logic [7:0] clamp_index(input logic [47:0] i, input int unsigned n);
        if (i >= 48'(n)) return 8'(n - 1);
        return i[7:0];
    endfunction

    // Find the four taps of a point; nearest uses one tap with zero weights
    function automatic t_taps locate(input logic [31:0] qx, input logic [31:0] qy);
        t_taps       t;
        logic [47:0] px, py, ix, iy;
        int unsigned w, h;
        logic        out_x, out_y;
        w = axis_extent(cfg_width, WIDTH_PX);
        h = axis_extent(cfg_height, HEIGHT_PX);
        out_x = map_axis(qx, cfg_origin_x, cfg_scale, w, px);
        out_y = map_axis(qy, cfg_origin_y, cfg_scale, h, py);
        t = '0;
        t.outside = out_x | out_y;
        if (cfg_method == METHOD_NEAREST) begin
            ix = (px + 48'h8000) >> 16;
            iy = (py + 48'h8000) >> 16;
            t.c0 = clamp_index(ix, w);
            t.c1 = t.c0;
            t.r0 = clamp_index(iy, h);
            t.r1 = t.r0;
        end else begin
            ix = px >> 16;
            iy = py >> 16;
            t.c0 = clamp_index(ix, w);
            t.c1 = clamp_index(ix + 48'd1, w);
            t.r0 = clamp_index(iy, h);
            t.r1 = clamp_index(iy + 48'd1, h);
            t.fx = px[15:0];
            t.fy = py[15:0];
        end
        return t;
    endfunction

    // Blend the taps into a Q8.8 gray level, rounding half up
    function automatic logic [15:0] interpolate(input t_taps t);
        logic [63:0] wx0, wy0, top, bot, acc;
        wx0 = 64'd65536 - 64'(t.fx);
        wy0 = 64'd65536 - 64'(t.fy);
        top = 64'(img_model[{t.r0, t.c0}]) * wx0 + 64'(img_model[{t.r0, t.c1}]) * 64'(t.fx);
        bot = 64'(img_model[{t.r1, t.c0}]) * wx0 + 64'(img_model[{t.r1, t.c1}]) * 64'(t.fx);
        acc = top * wy0 + bot * 64'(t.fy);
        return 16'((acc + 64'h80_0000) >> 24);
    endfunction

    // Apply one accepted item to the model; queue the sample it returns
    function automatic void predict_sample(input t_pixel_op op);
        t_taps   t;
        t_sample s;
        if (op.cmd == CMD_LOAD) begin
            img_model[{op.row, op.col}] = op.val;
        end else begin
            t = locate(op.qx, op.qy);
            s.outside = t.outside;
            s.value = t.outside ? 16'd0 : interpolate(t);
            expected_samples.push_back(s);
        end
    endfunction

    // Queue a load with junk in the query fields
    function automatic void push_load(input logic [7:0] col, input logic [7:0] row,
                                      input logic [7:0] val);
        t_pixel_op op;
        op.cmd = CMD_LOAD;
        op.col = col;
        op.row = row;
        op.val = val;
        op.qx = $urandom();
        op.qy = $urandom();
        gen_loaded[{row, col}] = 1'b1;
        pending_ops.push_back(op);
    endfunction

    // Queue a sample, first loading any tap that was never written
    function automatic void push_sample(input logic [31:0] qx, input logic [31:0] qy);
        t_pixel_op op;
        t_taps     t;
        t = locate(qx, qy);
        if (!t.outside) begin
            if (!gen_loaded[{t.r0, t.c0}]) push_load(t.c0, t.r0, 8'($urandom()));
            if (!gen_loaded[{t.r0, t.c1}]) push_load(t.c1, t.r0, 8'($urandom()));
            if (!gen_loaded[{t.r1, t.c0}]) push_load(t.c0, t.r1, 8'($urandom()));
            if (!gen_loaded[{t.r1, t.c1}]) push_load(t.c1, t.r1, 8'($urandom()));
        end
        op.cmd = CMD_SAMPLE;
        {op.col, op.row, op.val} = 24'($urandom());
        op.qx = qx;
        op.qy = qy;
        pending_ops.push_back(op);
    endfunction

    // Pick a world coordinate: mostly on the image, some at its edges, some noise
    function automatic logic [31:0] pick_coord(input logic [31:0] org, input int unsigned n);
        longint      d;
        int          off;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 12 || cfg_scale == 0) return $urandom();
        if (pick < 22) begin
            off = int'($urandom_range(2)) - 1;
            case ($urandom_range(3))
                0: d = -1;
                1: d = 0;
                default: d = longint'((64'(n) << 32) / {32'd0, cfg_scale}) + off;
            endcase
        end else begin
            d = longint'((64'($urandom_range(n * 65536)) << 16) / {32'd0, cfg_scale});
        end
        return 32'(longint'($signed(org)) + d);
    endfunction

    // Input driver: advance the queue on each transfer, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sent_op = pending_ops.pop_front();
                predict_sample(sent_op);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_ops[0].qy, pending_ops[0].qx, pending_ops[0].val,
                                     pending_ops[0].row, pending_ops[0].col};
                    s_axis_tuser <= pending_ops[0].cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transfer, stall at random or hold off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected result: value %h outside %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $display("%0t: sample_value mismatch: expected %h, actual %h",
                                 $time, want.value, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.outside) begin
                        $display("%0t: outside mismatch: expected %b, actual %b",
                                 $time, want.outside, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                hold_cnt++;
                if (hold_cnt == HOLD_CYCLES) hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Wait until every item is taken and every sample returned, then let the pipe empty
    task automatic settle();
        while (pending_ops.size() != 0 || expected_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
    endtask

    // Write all registers and update the model copy
    task automatic program_regs(input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] sc, input t_method m,
                                input logic [8:0] w, input logic [8:0] h);
        put_reg(CFG_ORIGIN_X, ox);
        put_reg(CFG_ORIGIN_Y, oy);
        put_reg(CFG_SCALE, sc);
        put_reg(CFG_METHOD, {31'd0, m});
        put_reg(CFG_IMAGE_WIDTH, {23'd0, w});
        put_reg(CFG_IMAGE_HEIGHT, {23'd0, h});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_origin_x = ox;
        cfg_origin_y = oy;
        cfg_scale = sc;
        cfg_method = m;
        cfg_width = w;
        cfg_height = h;
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random mix of loads and samples under the current settings; tap loads count too
    task automatic run_random(input int n_items);
        int unsigned w, h;
        logic [7:0]  col, row;
        int          start;
        w = axis_extent(cfg_width, WIDTH_PX);
        h = axis_extent(cfg_height, HEIGHT_PX);
        start = pending_ops.size();
        while (pending_ops.size() - start < n_items) begin
            if ($urandom_range(99) < 30) begin
                col = ($urandom_range(3) != 0) ? 8'($urandom_range(w - 1)) : 8'($urandom());
                row = ($urandom_range(3) != 0) ? 8'($urandom_range(h - 1)) : 8'($urandom());
                push_load(col, row, 8'($urandom()));
            end else begin
                push_sample(pick_coord(cfg_origin_x, w), pick_coord(cfg_origin_y, h));
            end
        end
    endtask

    // One phase: settle, reprogram, run two halves with a full pause between
    task automatic run_phase(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] sc, input t_method m,
                             input logic [8:0] w, input logic [8:0] h,
                             input int tx_idle, input int rx_stall,
                             input int n_items, input bit hold);
        settle();
        program_regs(ox, oy, sc, m, w, h);
        tx_idle_pct = tx_idle;
        rx_stall_pct = rx_stall;
        hold_req = hold;
        run_random(n_items / 2);
        settle();
        run_random(n_items - n_items / 2);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default geometry, bilinear, no idling
        program_regs(RST_ORIGIN, RST_ORIGIN, RST_SCALE, METHOD_BILINEAR,
                     RST_EXTENT, RST_EXTENT);
        tx_idle_pct = 0;
        rx_stall_pct = 0;

        // Directed: corner pixels, fractions, edge clamp, points just off the image
        push_load(8'd0, 8'd0, 8'd0);
        push_load(8'd255, 8'd255, 8'd255);
        push_load(8'd1, 8'd0, 8'd200);
        push_load(8'd0, 8'd1, 8'd100);
        push_load(8'd1, 8'd1, 8'd50);
        push_sample(32'h0000_0000, 32'h0000_0000);
        push_sample(32'h0000_8000, 32'h0000_8000);
        push_sample(32'h0000_4000, 32'h0000_C000);
        push_sample(32'h0001_0000, 32'h0000_8000);
        push_sample(32'h00FF_C000, 32'h00FF_C000);
        push_sample(32'h0100_0000, 32'h0100_0000);
        push_sample(32'h0100_0001, 32'h0000_0000);
        push_sample(32'h0000_0000, 32'h0100_0001);
        push_sample(32'hFFFF_FFFF, 32'h0000_0000);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000);
        run_random(60);

        // Offset origin, scale two, small image; sender idles
        run_phase(32'hFFFB_C000, 32'h0003_8000, 32'h0002_0000, METHOD_BILINEAR,
                  9'd16, 9'd12, 80, 0, 100, 1'b0);
        // Nearest, half scale, single column; receiver stalls
        run_phase(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, METHOD_NEAREST,
                  9'd1, 9'd200, 0, 80, 100, 1'b0);
        // Maximum scale, zero and oversized extents; long receiver hold-off
        run_phase(32'h7FFF_0000, 32'h8001_0000, 32'hFFFF_FFFF, METHOD_BILINEAR,
                  9'd0, 9'd511, 0, 0, 120, 1'b1);
        // Zero scale with extreme origins
        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, METHOD_NEAREST,
                  9'd256, 9'd256, 9, 9, 40, 1'b0);
        // Random settings, light idling, then none
        for (int k = 0; k < 2; k++) begin
            run_phase({{14{1'b0}}, 18'($urandom())} - 32'h0002_0000,
                      {{14{1'b0}}, 18'($urandom())} - 32'h0002_0000,
                      $urandom_range(32'h0004_0000, 32'h0000_4000),
                      t_method'($urandom_range(1)),
                      9'($urandom_range(256, 1)), 9'($urandom_range(256, 1)),
                      k == 0 ? 9 : 0, k == 0 ? 9 : 0, 100, 1'b0);
        end
        settle();

        if (expected_samples.size() != 0) fail_count++;
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/msu_pkg.sv
rtl/msu_front.sv
rtl/msu_queue.sv
rtl/msu_back.sv
rtl/mapped_image_sampler_unit.sv
test/mapped_image_sampler_unit_test.sv
